@@ hw/rtl/bddc_pkg.sv @@
// Binned depth distortion correction: shared types and constants.
// Holds the store entry layout, divider request/response words and the codes.
// No dependencies.
package bddc_pkg;

	localparam logic [17:0] MULT_ONE    = 18'd65536;
	localparam logic [17:0] MULT_MAX    = 18'h3FFFF;
	localparam logic [19:0] MM2_PER_M2  = 20'd1000000;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ZERO   = 2'd1;
	localparam logic [1:0] ST_REJECT = 2'd2;
	localparam logic [1:0] ST_GRID   = 2'd3;

	localparam logic KIND_CORRECT = 1'b0;
	localparam logic KIND_TRAIN   = 1'b1;

	localparam logic [2:0] REG_CELL_W    = 3'd0;
	localparam logic [2:0] REG_CELL_H    = 3'd1;
	localparam logic [2:0] REG_BIN_MM    = 3'd2;
	localparam logic [2:0] REG_BINS_USED = 3'd3;
	localparam logic [2:0] REG_PRIOR     = 3'd4;
	localparam logic [2:0] REG_MIN_HITS  = 3'd5;
	localparam logic [2:0] REG_RATIO_MIN = 3'd6;
	localparam logic [2:0] REG_RATIO_MAX = 3'd7;

	typedef struct packed {
		logic [31:0] hits;
		logic [63:0] tsq;
		logic [63:0] cps;
		logic [17:0] mult;
	} entry_t;

	typedef struct packed {
		logic        start;
		logic [63:0] rem_init;
		logic [17:0] bits;
		logic [4:0]  count;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [17:0] quot;
	} div_rsp_t;

endpackage

@@ hw/rtl/bddc_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
// Takes a partial remainder below the divisor and up to 18 dividend bits.
// Depends on bddc_pkg.
module bddc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bddc_pkg::div_req_t req,
	output bddc_pkg::div_rsp_t rsp
);
	import bddc_pkg::*;

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [63:0] rem_q;
	logic [17:0] bits_q;
	logic [17:0] quot_q;
	logic [63:0] den_q;
	logic [64:0] shifted;
	logic [64:0] trial;
	logic        ge;

	assign shifted = {rem_q, bits_q[17]};
	assign ge      = shifted >= {1'b0, den_q};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.count;
				rem_q  <= req.rem_init;
				bits_q <= req.bits;
				den_q  <= req.den;
				quot_q <= '0;
			end else if (busy_q) begin
				rem_q  <= ge ? trial[63:0] : shifted[63:0];
				quot_q <= {quot_q[16:0], ge};
				bits_q <= {bits_q[16:0], 1'b0};
				cnt_q  <= cnt_q - 5'd1;
				if (cnt_q == 5'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

@@ hw/rtl/bddc_store.sv @@
// Per cell and bin store: hit count, both sums and multiplier.
// One write and one registered read port. Depends on bddc_pkg.
module bddc_store #(
	parameter int ENTRIES = 262144,
	parameter int AW      = 18
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  bddc_pkg::entry_t wr_data,
	input  logic [AW-1:0]    rd_addr,
	output bddc_pkg::entry_t rd_data
);
	import bddc_pkg::*;

	entry_t mem [ENTRIES];
	entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule

@@ hw/rtl/binned_depth_distortion_correct.sv @@
// Binned depth distortion correction, top level: sequencer, shared multiplier and divider.
// One word at a time; accept to next accept is set by the divider passes: three for
// a plain correct word, four interpolated or training (three if rejected or saturated),
// none for zero depth, two outside the grid, plus any wait on a full result register.
// Reset and a prior_weight write sweep the store, one entry a cycle, over all
// CELL_COLS*CELL_ROWS*DEPTH_BINS entries, with item_ready low meanwhile.
module binned_depth_distortion_correct #(
	parameter int CELL_COLS  = 128,
	parameter int CELL_ROWS  = 128,
	parameter int DEPTH_BINS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        kind,
	input  logic [9:0]  pixel_col,
	input  logic [9:0]  pixel_row,
	input  logic [15:0] depth_mm,
	input  logic [15:0] truth_mm,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [15:0] corrected_mm,
	output logic [1:0]  status,
	output logic [31:0] samples_total,
	input  logic        cfg_write,
	input  logic [2:0]  cfg_index,
	input  logic [17:0] cfg_data
);
	import bddc_pkg::*;

	localparam int ENTRIES = CELL_COLS * CELL_ROWS * DEPTH_BINS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CELLS   = CELL_COLS * CELL_ROWS;
	localparam int CW      = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int NBW     = $clog2(DEPTH_BINS + 1);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_DIVX, S_DIVY, S_DIVB,
		S_TMAX, S_TMIN, S_TCHK, S_TSQ, S_TCP, S_TSAT, S_TDIV, S_TWR,
		S_CSTART, S_CHI, S_PRD, S_HLO, S_HHI, S_PMUL, S_PFIN,
		S_I1, S_I2, S_I3, S_I4, S_I5, S_I6, S_IDIV, S_DONE
	} state_t;

	state_t      state_q;
	logic [AW-1:0] clr_q;

	logic [10:0] cw_q, ch_q;
	logic [13:0] b_q;
	logic [4:0]  nb_q;
	logic [7:0]  prior_q;
	logic [27:0] pmm2_q;
	logic [15:0] minh_q;
	logic [17:0] rmin_q, rmax_q;

	logic           kind_q;
	logic [9:0]     row_q, cx_q;
	logic [15:0]    d_q, t_q;
	logic [CW-1:0]  cell_q;
	logic [NBW-1:0] bin_q, hi_q;
	logic           rej_q, lo_ok_q;
	logic [17:0]    m_q, m0_q, m1_q, mult_q;
	logic [14:0]    tt_q;
	logic [33:0]    mix_q;
	logic [31:0]    hits_q;
	logic [63:0]    tsq_q, cps_q;
	logic [51:0]    prod_q;
	logic [31:0]    acc_q;
	logic [15:0]    cor_q;
	logic [1:0]     stat_q;
	logic           res_valid_q;
	logic [15:0]    res_cor_q;
	logic [1:0]     res_stat_q;
	logic [31:0]    res_tot_q;

	logic [10:0]    cw_e, ch_e;
	logic [13:0]    b_e;
	logic [NBW-1:0] nb_e, nbm1;
	logic [14:0]    span2;
	logic [33:0]    mul_a;
	logic [17:0]    mul_b;
	logic [16:0]    diff;
	logic [NBW-1:0] hi_c;
	logic           plain_c;
	logic           zero_c, grid_c;
	logic [21:0]    tt_full;
	logic [14:0]    tt_c, w0_c;
	logic [64:0]    tsq_sum, cps_sum;
	logic           qsat_c, isat_c;
	logic [AW-1:0]  base_c;
	logic           accept;

	div_req_t div_req;
	div_rsp_t div_rsp;
	logic          wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	entry_t        wr_data, rd_data;

	assign cw_e  = (cw_q == 11'd0) ? 11'd1 : cw_q;
	assign ch_e  = (ch_q == 11'd0) ? 11'd1 : ch_q;
	assign b_e   = (b_q == 14'd0) ? 14'd1 : b_q;
	assign nb_e  = (nb_q == 5'd0) ? NBW'(1) :
		((32'(nb_q) > DEPTH_BINS) ? NBW'(DEPTH_BINS) : NBW'(nb_q));
	assign nbm1  = nb_e - NBW'(1);
	assign span2 = {b_e, 1'b0};

	assign accept = item_valid && item_ready;
	assign zero_c = (depth_mm == 16'd0) || (kind == KIND_TRAIN && truth_mm == 16'd0);
	assign grid_c = (11'(cx_q) >= 11'(CELL_COLS)) || (div_rsp.quot >= 18'(CELL_ROWS));

	assign diff    = 17'(d_q) - prod_q[16:0];
	assign hi_c    = ({diff, 1'b0} < 18'(b_e)) ? bin_q : bin_q + NBW'(1);
	assign plain_c = (hi_c == '0) || (hi_c >= nb_e);

	assign tt_full = 22'({d_q, 1'b0}) - prod_q[21:0];
	assign tt_c    = tt_full[14:0];
	assign w0_c    = (tt_c < span2) ? span2 - tt_c : 15'd0;

	assign tsq_sum = {1'b0, rd_data.tsq} + 65'(prod_q[31:0]);
	assign cps_sum = {1'b0, cps_q} + 65'(prod_q[31:0]);
	assign qsat_c  = {2'b00, tsq_q} >= {cps_q, 2'b00};
	assign isat_c  = prod_q >= 52'({span2, 32'd0});

	assign base_c  = AW'(cell_q) * AW'(DEPTH_BINS);

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_TMAX:   begin mul_a = 34'(rmax_q); mul_b = 18'(d_q); end
			S_TMIN:   begin mul_a = 34'(rmin_q); mul_b = 18'(d_q); end
			S_TCHK:   begin mul_a = 34'(t_q);    mul_b = 18'(t_q); end
			S_TSQ:    begin mul_a = 34'(t_q);    mul_b = 18'(d_q); end
			S_CSTART: begin mul_a = 34'(b_e);    mul_b = 18'(bin_q); end
			S_PMUL:   begin mul_a = 34'(d_q);    mul_b = m_q; end
			S_I1:     begin mul_a = 34'(b_e);    mul_b = 18'({hi_q, 1'b0}) - 18'd1; end
			S_I2:     begin mul_a = 34'(w0_c);   mul_b = m0_q; end
			S_I3:     begin mul_a = 34'(tt_q);   mul_b = m1_q; end
			S_I5:     begin mul_a = mix_q;       mul_b = 18'(d_q); end
			default:  begin mul_a = '0;          mul_b = '0; end
		endcase
	end

	always_comb begin
		div_req          = '0;
		div_req.rem_init = '0;
		case (state_q)
			S_IDLE: begin
				div_req.start = accept && !zero_c;
				div_req.bits  = {pixel_col, 8'd0};
				div_req.count = 5'd10;
				div_req.den   = 64'(cw_e);
			end
			S_DIVX: begin
				div_req.start = div_rsp.done;
				div_req.bits  = {row_q, 8'd0};
				div_req.count = 5'd10;
				div_req.den   = 64'(ch_e);
			end
			S_DIVY: begin
				div_req.start = div_rsp.done && !grid_c;
				div_req.bits  = {d_q, 2'd0};
				div_req.count = 5'd16;
				div_req.den   = 64'(b_e);
			end
			S_TSAT: begin
				div_req.start    = !qsat_c;
				div_req.rem_init = {2'b00, tsq_q[63:2]};
				div_req.bits     = {tsq_q[1:0], 16'd0};
				div_req.count    = 5'd18;
				div_req.den      = cps_q;
			end
			S_I6: begin
				div_req.start    = !isat_c;
				div_req.rem_init = 64'(prod_q[51:16]);
				div_req.bits     = {prod_q[15:0], 2'd0};
				div_req.count    = 5'd16;
				div_req.den      = 64'({span2, 16'd0});
			end
			default: div_req = '0;
		endcase
	end

	always_comb begin
		rd_addr = base_c + AW'(bin_q);
		case (state_q)
			S_CHI:   rd_addr = plain_c ? base_c + AW'(bin_q) : base_c + AW'(hi_c - NBW'(1));
			S_HLO:   rd_addr = base_c + AW'(hi_q);
			default: rd_addr = base_c + AW'(bin_q);
		endcase
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = base_c + AW'(bin_q);
		wr_data = '{hits: hits_q, tsq: tsq_q, cps: cps_q, mult: mult_q};
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '{hits: 32'(prior_q), tsq: 64'(pmm2_q), cps: 64'(pmm2_q),
					mult: MULT_ONE};
			end
			S_TWR:   wr_en = 1'b1;
			default: wr_en = 1'b0;
		endcase
	end

	bddc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	bddc_store #(
		.ENTRIES (ENTRIES),
		.AW      (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			cw_q        <= 11'd8;
			ch_q        <= 11'd6;
			b_q         <= 14'd1000;
			nb_q        <= 5'd10;
			prior_q     <= 8'd1;
			pmm2_q      <= 28'd1000000;
			minh_q      <= 16'd50;
			rmin_q      <= 18'd52429;
			rmax_q      <= 18'd78643;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			prod_q <= 52'(mul_a) * 52'(mul_b);
			if (res_valid_q && result_ready && state_q != S_DONE) begin
				res_valid_q <= 1'b0;
			end
			if (cfg_write) begin
				case (cfg_index)
					REG_CELL_W:    cw_q   <= cfg_data[10:0];
					REG_CELL_H:    ch_q   <= cfg_data[10:0];
					REG_BIN_MM:    b_q    <= cfg_data[13:0];
					REG_BINS_USED: nb_q   <= cfg_data[4:0];
					REG_MIN_HITS:  minh_q <= cfg_data[15:0];
					REG_RATIO_MIN: rmin_q <= cfg_data;
					REG_RATIO_MAX: rmax_q <= cfg_data;
					REG_PRIOR: begin
						prior_q <= cfg_data[7:0];
						pmm2_q  <= 28'(cfg_data[7:0]) * 28'(MM2_PER_M2);
						acc_q   <= '0;
					end
					default: cw_q <= cw_q;
				endcase
			end
			if (cfg_write && cfg_index == REG_PRIOR) begin
				clr_q   <= '0;
				state_q <= S_CLEAR;
			end else begin
				case (state_q)
					S_CLEAR: begin
						clr_q <= clr_q + AW'(1);
						if (clr_q == AW'(ENTRIES - 1)) begin
							state_q <= S_IDLE;
						end
					end
					S_IDLE: begin
						if (accept) begin
							kind_q <= kind;
							row_q  <= pixel_row;
							d_q    <= depth_mm;
							t_q    <= truth_mm;
							if (zero_c) begin
								cor_q   <= 16'd0;
								stat_q  <= ST_ZERO;
								state_q <= S_DONE;
							end else begin
								state_q <= S_DIVX;
							end
						end
					end
					S_DIVX: begin
						if (div_rsp.done) begin
							cx_q    <= div_rsp.quot[9:0];
							state_q <= S_DIVY;
						end
					end
					S_DIVY: begin
						if (div_rsp.done) begin
							if (grid_c) begin
								cor_q   <= (kind_q == KIND_TRAIN) ? 16'd0 : d_q;
								stat_q  <= ST_GRID;
								state_q <= S_DONE;
							end else begin
								cell_q  <= CW'(div_rsp.quot) * CW'(CELL_COLS) + CW'(cx_q);
								state_q <= S_DIVB;
							end
						end
					end
					S_DIVB: begin
						if (div_rsp.done) begin
							bin_q   <= (div_rsp.quot >= 18'(nbm1)) ? nbm1 : NBW'(div_rsp.quot);
							state_q <= (kind_q == KIND_TRAIN) ? S_TMAX : S_CSTART;
						end
					end
					S_TMAX: state_q <= S_TMIN;
					S_TMIN: begin
						rej_q   <= 52'({t_q, 16'd0}) > prod_q;
						state_q <= S_TCHK;
					end
					S_TCHK: begin
						if (rej_q || 52'({t_q, 16'd0}) < prod_q) begin
							cor_q   <= 16'd0;
							stat_q  <= ST_REJECT;
							state_q <= S_DONE;
						end else begin
							state_q <= S_TSQ;
						end
					end
					S_TSQ: begin
						tsq_q   <= tsq_sum[64] ? '1 : tsq_sum[63:0];
						cps_q   <= rd_data.cps;
						hits_q  <= (rd_data.hits == '1) ? rd_data.hits : rd_data.hits + 32'd1;
						state_q <= S_TCP;
					end
					S_TCP: begin
						cps_q   <= cps_sum[64] ? '1 : cps_sum[63:0];
						state_q <= S_TSAT;
					end
					S_TSAT: begin
						if (qsat_c) begin
							mult_q  <= MULT_MAX;
							state_q <= S_TWR;
						end else begin
							state_q <= S_TDIV;
						end
					end
					S_TDIV: begin
						if (div_rsp.done) begin
							mult_q  <= div_rsp.quot;
							state_q <= S_TWR;
						end
					end
					S_TWR: begin
						if (acc_q != '1) begin
							acc_q <= acc_q + 32'd1;
						end
						cor_q   <= 16'd0;
						stat_q  <= ST_OK;
						state_q <= S_DONE;
					end
					S_CSTART: state_q <= S_CHI;
					S_CHI: begin
						hi_q    <= hi_c;
						state_q <= plain_c ? S_PRD : S_HLO;
					end
					S_PRD: begin
						m_q     <= rd_data.mult;
						state_q <= S_PMUL;
					end
					S_HLO: begin
						lo_ok_q <= rd_data.hits >= 32'(minh_q);
						m0_q    <= rd_data.mult;
						state_q <= S_HHI;
					end
					S_HHI: begin
						if (lo_ok_q && rd_data.hits >= 32'(minh_q)) begin
							m1_q    <= rd_data.mult;
							state_q <= S_I1;
						end else begin
							m_q     <= (hi_q == bin_q) ? rd_data.mult : m0_q;
							state_q <= S_PMUL;
						end
					end
					S_PMUL: state_q <= S_PFIN;
					S_PFIN: begin
						cor_q   <= (prod_q[51:32] != '0) ? 16'hFFFF : prod_q[31:16];
						stat_q  <= ST_OK;
						state_q <= S_DONE;
					end
					S_I1: state_q <= S_I2;
					S_I2: begin
						tt_q    <= tt_c;
						state_q <= S_I3;
					end
					S_I3: begin
						mix_q   <= prod_q[33:0];
						state_q <= S_I4;
					end
					S_I4: begin
						mix_q   <= mix_q + prod_q[33:0];
						state_q <= S_I5;
					end
					S_I5: state_q <= S_I6;
					S_I6: begin
						stat_q <= ST_OK;
						if (isat_c) begin
							cor_q   <= 16'hFFFF;
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDIV;
						end
					end
					S_IDIV: begin
						if (div_rsp.done) begin
							cor_q   <= div_rsp.quot[15:0];
							state_q <= S_DONE;
						end
					end
					S_DONE: begin
						if (!res_valid_q || result_ready) begin
							res_valid_q <= 1'b1;
							res_cor_q   <= cor_q;
							res_stat_q  <= stat_q;
							res_tot_q   <= acc_q;
							state_q     <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	assign item_ready    = (state_q == S_IDLE);
	assign result_valid  = res_valid_q;
	assign corrected_mm  = res_cor_q;
	assign status        = res_stat_q;
	assign samples_total = res_tot_q;

endmodule
